[hw/rtl/dfm_pkg.sv]
// Shared types, constants and stage records of the decimal float multiplier.
// No dependencies; every other file of the block but dfm_checker imports this package.
`timescale 1ns / 1ps

package dfm_pkg;

  // Rounding directions held in the configuration register
  typedef enum logic [1:0] {
    RM_NEAREST_EVEN = 2'd0,
    RM_TOWARD_POS   = 2'd1,
    RM_TOWARD_NEG   = 2'd2,
    RM_TOWARD_ZERO  = 2'd3
  } rnd_dir_t;

  // Encoding of special values
  localparam logic [6:0]  EXP_SPECIAL = 7'h40;         // exponent field of -64
  localparam logic [23:0] SIG_ALL_ONES = 24'hFFFFFF;
  localparam logic [31:0] ZERO_WORD = 32'h8000_0000;
  localparam logic [31:0] INF_WORD  = 32'h80FF_FFFF;
  localparam logic [31:0] NAN_WORD  = 32'h8000_00FF;
  localparam logic [31:0] SGN_MASK  = 32'h0100_0000;

  // Exponent limits
  localparam logic signed [7:0] EXP_MAX       = 8'sd63;
  localparam logic signed [7:0] EXP_MIN       = -8'sd63;
  localparam logic signed [7:0] EXP_MIN_EARLY = -8'sd64;

  // Division constants; 10^6 = 64 * 15625
  localparam logic [47:0] BIG_LIMIT    = 48'd10_000_000_000_000;
  localparam logic [28:0] RECIP_15625  = 29'd281474976;   // floor(2^42 / 15625)
  localparam logic [31:0] RECIP_10     = 32'hCCCC_CCCD;   // ceil(2^35 / 10)
  localparam logic [16:0] DIV_LO       = 17'd15625;
  localparam logic [16:0] DIV_LO2      = 17'd31250;
  localparam logic [23:0] DEC6         = 24'd1_000_000;
  localparam logic [23:0] DEC7         = 24'd10_000_000;

  // Fields that ride along every stage
  typedef struct packed {
    logic        special;     // result already known
    logic [31:0] spec_word;   // that result
    logic        neg;         // sign of the product
    logic [7:0]  exp;         // two's complement exponent sum
  } meta_t;

  typedef struct packed {
    meta_t       meta;
    logic [47:0] prod;
  } s1_t;

  typedef struct packed {
    meta_t       meta;
    logic        big;
    logic [28:0] q_est;
    logic [16:0] x_lo;
    logic [5:0]  p_lo;
    logic [16:0] t_lo;
  } s2_t;

  typedef struct packed {
    meta_t       meta;
    logic        big;
    logic [28:0] q6;
    logic [19:0] r6;
    logic [24:0] q7;
  } s4_t;

  typedef struct packed {
    meta_t       meta;
    logic        big;
    logic [28:0] q;
    logic [23:0] rem;
  } s6_t;

  // Stage enables handed to the divider stages
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } div_en_t;

endpackage

[hw/rtl/dfm_front.sv]
// Stage 1: operand classification, special results, exponent sum and
// 24x24 significand product. Depends on dfm_pkg.
`timescale 1ns / 1ps

module dfm_front (
  input  logic          clk,
  input  logic          en,
  input  logic [31:0]   left_operand,
  input  logic [31:0]   right_operand,
  output dfm_pkg::s1_t  s1_r
);
  import dfm_pkg::*;

  logic [23:0]       sig_a, sig_b;
  logic              spec_a, spec_b;
  logic              nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
  logic              neg;
  logic signed [7:0] esum;
  logic [31:0]       sgn;
  s1_t               s1_nxt;

  // Classify both operands
  always_comb begin
    sig_a  = left_operand[23:0];
    sig_b  = right_operand[23:0];
    spec_a = (left_operand[31:25] == EXP_SPECIAL);
    spec_b = (right_operand[31:25] == EXP_SPECIAL);
    inf_a  = spec_a && (sig_a == SIG_ALL_ONES);
    inf_b  = spec_b && (sig_b == SIG_ALL_ONES);
    zero_a = spec_a && (sig_a == '0);
    zero_b = spec_b && (sig_b == '0);
    nan_a  = spec_a && !inf_a && !zero_a;
    nan_b  = spec_b && !inf_b && !zero_b;
    neg    = left_operand[24] ^ right_operand[24];
    sgn    = neg ? SGN_MASK : '0;
    esum   = $signed({left_operand[31], left_operand[31:25]}) +
             $signed({right_operand[31], right_operand[31:25]});
  end

  // Special result selection, in priority order
  always_comb begin
    s1_nxt.meta.neg       = neg;
    s1_nxt.meta.exp       = esum;
    s1_nxt.meta.special   = 1'b1;
    s1_nxt.meta.spec_word = '0;
    s1_nxt.prod           = 48'(sig_a) * 48'(sig_b);
    if (nan_a) begin
      s1_nxt.meta.spec_word = left_operand;
    end else if (nan_b) begin
      s1_nxt.meta.spec_word = right_operand;
    end else if ((inf_a && zero_b) || (zero_a && inf_b)) begin
      s1_nxt.meta.spec_word = NAN_WORD | sgn;
    end else if (inf_a || inf_b) begin
      s1_nxt.meta.spec_word = INF_WORD | sgn;
    end else if (zero_a || zero_b) begin
      s1_nxt.meta.spec_word = ZERO_WORD | sgn;
    end else if (esum > EXP_MAX) begin
      s1_nxt.meta.spec_word = INF_WORD | sgn;
    end else if (esum < EXP_MIN_EARLY) begin
      s1_nxt.meta.spec_word = ZERO_WORD | sgn;
    end else begin
      s1_nxt.meta.special = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
    end
  end

endmodule

[hw/rtl/dfm_div.sv]
// Stages 2 to 6: divides the significand product by 10^6 or 10^7 through
// reciprocal multiplies with remainder correction. Depends on dfm_pkg.
`timescale 1ns / 1ps

module dfm_div (
  input  logic              clk,
  input  dfm_pkg::div_en_t  en,
  input  dfm_pkg::s1_t      s1,
  output dfm_pkg::s6_t      s6_r
);
  import dfm_pkg::*;

  s2_t         s2_r, s2_nxt;
  s2_t         s3_r, s3_nxt;
  s4_t         s4_r, s4_nxt;
  s4_t         s5_r, s5_nxt;
  s6_t         s6_nxt;
  logic [60:0] m_est;
  logic [60:0] m_ten;
  logic [16:0] r0;
  logic [13:0] rq;
  logic [3:0]  dig;
  logic [23:0] rem7;

  // Stage 2: quotient estimate of (p >> 6) / 15625 from the top 32 bits
  always_comb begin
    m_est         = 61'(s1.prod[47:16]) * 61'(RECIP_15625);
    s2_nxt.meta   = s1.meta;
    s2_nxt.big    = (s1.prod >= BIG_LIMIT);
    s2_nxt.q_est  = m_est[60:32];
    s2_nxt.x_lo   = s1.prod[22:6];
    s2_nxt.p_lo   = s1.prod[5:0];
    s2_nxt.t_lo   = '0;
  end

  // Stage 3: low bits of estimate * 15625; the true remainder fits in 17 bits
  always_comb begin
    s3_nxt      = s2_r;
    s3_nxt.t_lo = s2_r.q_est[16:0] * DIV_LO;
  end

  // Stage 4: estimate is short by at most two; fix quotient and remainder
  always_comb begin
    r0 = s3_r.x_lo - s3_r.t_lo;
    s4_nxt.meta = s3_r.meta;
    s4_nxt.big  = s3_r.big;
    s4_nxt.q7   = '0;
    if (r0 >= DIV_LO2) begin
      s4_nxt.q6 = s3_r.q_est + 29'd2;
      rq        = 14'(r0 - DIV_LO2);
    end else if (r0 >= DIV_LO) begin
      s4_nxt.q6 = s3_r.q_est + 29'd1;
      rq        = 14'(r0 - DIV_LO);
    end else begin
      s4_nxt.q6 = s3_r.q_est;
      rq        = r0[13:0];
    end
    s4_nxt.r6 = {rq, s3_r.p_lo};
  end

  // Stage 5: q6 / 10 for the 10^7 case
  always_comb begin
    m_ten     = 61'(s4_r.q6) * 61'(RECIP_10);
    s5_nxt    = s4_r;
    s5_nxt.q7 = m_ten[59:35];
  end

  // Stage 6: pick quotient and remainder for the selected divisor
  always_comb begin
    dig  = s5_r.q6[3:0] - 4'(s5_r.q7[3:0] * 4'd10);
    rem7 = 24'(dig) * DEC6 + 24'(s5_r.r6);
    s6_nxt.meta = s5_r.meta;
    s6_nxt.big  = s5_r.big;
    s6_nxt.q    = s5_r.big ? 29'(s5_r.q7) : s5_r.q6;
    s6_nxt.rem  = s5_r.big ? rem7 : 24'(s5_r.r6);
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      s2_r <= s2_nxt;
    end
    if (en.s3) begin
      s3_r <= s3_nxt;
    end
    if (en.s4) begin
      s4_r <= s4_nxt;
    end
    if (en.s5) begin
      s5_r <= s5_nxt;
    end
    if (en.s6) begin
      s6_r <= s6_nxt;
    end
  end

endmodule

[hw/rtl/dfm_round.sv]
// Stage 7: directed rounding, exponent range check and result packing into
// the output register. Depends on dfm_pkg.
`timescale 1ns / 1ps

module dfm_round (
  input  logic                  clk,
  input  logic                  en,
  input  dfm_pkg::rnd_dir_t     rnd_dir,
  input  dfm_pkg::s6_t          s6,
  output logic [31:0]           product_r
);
  import dfm_pkg::*;

  logic [24:0]       rem2;
  logic [24:0]       divisor;
  logic              inc;
  logic              has_rem;
  logic [23:0]       q_rnd;
  logic signed [7:0] e_fin;
  logic [31:0]       sgn;
  logic [31:0]       product_nxt;

  // Round-up decision
  always_comb begin
    rem2    = {s6.rem, 1'b0};
    divisor = s6.big ? 25'(DEC7) : 25'(DEC6);
    has_rem = (s6.rem != '0);
    case (rnd_dir)
      RM_NEAREST_EVEN: inc = (rem2 > divisor) || ((rem2 == divisor) && s6.q[0]);
      RM_TOWARD_POS:   inc = has_rem && !s6.meta.neg;
      RM_TOWARD_NEG:   inc = has_rem && s6.meta.neg;
      RM_TOWARD_ZERO:  inc = 1'b0;
      default:         inc = 1'b0;
    endcase
    q_rnd = s6.q[23:0] + 24'(inc);
  end

  // Final exponent and packing
  always_comb begin
    e_fin = $signed(s6.meta.exp) + $signed({7'b0, s6.big});
    sgn   = s6.meta.neg ? SGN_MASK : '0;
    if (s6.meta.special) begin
      product_nxt = s6.meta.spec_word;
    end else if (e_fin > EXP_MAX) begin
      product_nxt = INF_WORD | sgn;
    end else if (e_fin < EXP_MIN) begin
      product_nxt = ZERO_WORD | sgn;
    end else begin
      product_nxt = {e_fin[6:0], s6.meta.neg, q_rnd};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      product_r <= product_nxt;
    end
  end

endmodule

[hw/rtl/decimal_float_multiplier_top.sv]
// Top level of the 7-digit decimal float multiplier: stage valid bits, stall
// chain, rounding-mode register. Depends on dfm_pkg, dfm_front, dfm_div, dfm_round.
`timescale 1ns / 1ps
//
//  channel  direction  handshake              payload
//  in       input      in_valid / in_stall    in_left_operand, in_right_operand
//  out      output     out_valid / out_stall  out_product
//  cfg      input      cfg_valid / cfg_ready  cfg_rnd_dir
//
//  Seven register stages; with no stall they take one request per cycle.
//  The two reciprocal multipliers and the 24x24 product set the stage depth.
//  Each stage loads whenever it is empty or the next one moves, so bubbles
//  close up under out_stall and in_stall rises only when all stages are full.
//  rst_n (synchronous) clears the valid bits and sets nearest-even rounding.

module decimal_float_multiplier_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_left_operand,
  input  logic [31:0] in_right_operand,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_product,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_rnd_dir
);
  import dfm_pkg::*;

  rnd_dir_t    rnd_dir_r;
  logic [6:1]  vld_r, vld_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:1]  stage_en;
  div_en_t     div_en;
  s1_t         s1;
  s6_t         s6;

  // Configuration register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_dir_r <= RM_NEAREST_EVEN;
    end else if (cfg_valid) begin
      rnd_dir_r <= rnd_dir_t'(cfg_rnd_dir);
    end
  end

  // Stall chain: a stage moves when empty or when its successor moves
  always_comb begin
    stage_en[7] = !out_valid_r || !out_stall;
    for (int k = 6; k >= 1; k--) begin
      stage_en[k] = !vld_r[k] || stage_en[k+1];
    end
  end

  // Valid bits travel with the data
  always_comb begin
    vld_nxt[1] = stage_en[1] ? in_valid : vld_r[1];
    for (int k = 2; k <= 6; k++) begin
      vld_nxt[k] = stage_en[k] ? vld_r[k-1] : vld_r[k];
    end
    out_valid_nxt = stage_en[7] ? vld_r[6] : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign div_en = '{s2: stage_en[2], s3: stage_en[3], s4: stage_en[4],
                    s5: stage_en[5], s6: stage_en[6]};

  assign in_stall  = !stage_en[1];
  assign out_valid = out_valid_r;

  dfm_front u_front (
    .clk           (clk),
    .en            (stage_en[1]),
    .left_operand  (in_left_operand),
    .right_operand (in_right_operand),
    .s1_r          (s1)
  );

  dfm_div u_div (
    .clk  (clk),
    .en   (div_en),
    .s1   (s1),
    .s6_r (s6)
  );

  dfm_round u_round (
    .clk        (clk),
    .en         (stage_en[7]),
    .rnd_dir    (rnd_dir_r),
    .s6         (s6),
    .product_r  (out_product)
  );

endmodule

[hw/rtl/dfm_checker.sv]
// Port-level checks of the decimal float multiplier, bound to its top level.
// Depends only on the top-level ports.
`timescale 1ns / 1ps

module dfm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_product
);

  logic       in_acc, out_acc, run_ok;
  logic [3:0] cnt_r, cnt_nxt;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign run_ok  = rst_n && !out_stall;

  // Requests inside the block
  always_comb begin
    cnt_nxt = cnt_r + 4'(in_acc) - 4'(out_acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // No result without a pending request, never more than seven in flight
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (cnt_r != 4'd0) && (cnt_r <= 4'd7))
    else $error("result without pending request or overfull pipeline");

  // An empty output register never holds back the input
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while output register is empty");

  // Free-running pipeline: with out_stall low, an accepted request reaches the output
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(in_acc, 7) && $past(run_ok, 1) && $past(run_ok, 2) && $past(run_ok, 3) &&
     $past(run_ok, 4) && $past(run_ok, 5) && $past(run_ok, 6)) |-> out_valid)
    else $error("result missing seven cycles after request");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_product)))
    else $error("stalled result changed");

endmodule

bind decimal_float_multiplier_top dfm_checker u_dfm_checker (.*);
